/* rtl/ced_pkg.sv */
// Shared types and constants for the exception priority dispatch block.
// No dependencies; every other file in rtl/ imports this package.
package ced_pkg;

  // One input beat: pending flags plus the architectural state to update.
  typedef struct packed {
    logic [7:0]  pending;
    logic [31:0] msr_in;
    logic [31:0] cur_pc;
    logic [31:0] next_pc;
    logic [31:0] save_pc_in;
    logic [31:0] save_msr_in;
  } ced_in_t;

  // One result beat: the updated state after dispatch.
  typedef struct packed {
    logic        taken;
    logic [3:0]  cause;
    logic [31:0] save_pc_out;
    logic [31:0] save_msr_out;
    logic [31:0] msr_out;
    logic [31:0] next_pc_out;
    logic [7:0]  pending_out;
  } ced_out_t;

  localparam int unsigned NUM_EXC = 8;
  localparam int unsigned SEL_W   = $clog2(NUM_EXC);

  // Exception indexes, in priority order (lowest index wins).
  localparam logic [SEL_W-1:0] EXC_ISI     = 3'd0;
  localparam logic [SEL_W-1:0] EXC_PROGRAM = 3'd1;
  localparam logic [SEL_W-1:0] EXC_SYSCALL = 3'd2;
  localparam logic [SEL_W-1:0] EXC_FPU     = 3'd3;
  localparam logic [SEL_W-1:0] EXC_DSI     = 3'd4;
  localparam logic [SEL_W-1:0] EXC_ALIGN   = 3'd5;
  localparam logic [SEL_W-1:0] EXC_EXT     = 3'd6;
  localparam logic [SEL_W-1:0] EXC_DEC     = 3'd7;

  localparam logic [3:0] CAUSE_NONE = 4'd0;

  // Flags that are always eligible, and those gated by MSR.EE.
  localparam logic [NUM_EXC-1:0] SYNC_EXC_MASK  = 8'h3F;
  localparam logic [NUM_EXC-1:0] ASYNC_EXC_MASK = 8'hC0;

  localparam logic [31:0] SRR1_KEEP_MASK = 32'h87C0_FFFF;
  localparam logic [31:0] MSR_CLEAR_MASK = 32'h0004_EF36;
  localparam logic [31:0] PROG_SRR1_BIT  = 32'h0004_0000;
  localparam logic [31:0] MSR_EE         = 32'h0000_8000;
  localparam int unsigned MSR_ILE_BIT    = 16;
  localparam int unsigned MSR_LE_BIT     = 0;

  // Vector address for each exception index.
  localparam logic [31:0] VEC_TABLE [NUM_EXC] = '{
    32'h8000_0400,  // isi
    32'h8000_0700,  // program
    32'h8000_0C00,  // syscall
    32'h8000_0800,  // fpu unavailable
    32'h8000_0300,  // dsi
    32'h8000_0600,  // alignment
    32'h8000_0500,  // external
    32'h8000_0900   // decrementer
  };

  // Bit set where SRR0 saves the next instruction address instead of the current.
  localparam logic [NUM_EXC-1:0] USE_NEXT_PC = 8'b1100_0101;

endpackage

/* rtl/cpu_exception_priority_dispatch.sv */
// Top level of the exception priority dispatch block.
// Depends on ced_pkg, ced_in_reg and ced_dispatch.
//
// Usage:
// Each input beat carries the pending-exception flags and the current MSR,
// PC, NPC, SRR0 and SRR1. Each beat yields exactly one result beat holding
// the chosen cause and the updated SRR0, SRR1, MSR, NPC and pending flags.
// Both channels use valid and stall; a beat moves when valid is high and
// stall is low. The path is an input register, the priority select and
// update logic, and a result register. A result is presented once its
// input beat has passed both registers; one beat per cycle is sustained as
// long as the result side does not stall. When the result side stalls, the
// result register holds its beat and the input register keeps at most one
// more; in_stall rises only once both are full. Reset clears both valid
// flags, so no result is presented until a new input beat arrives.
module cpu_exception_priority_dispatch (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ced_pkg::ced_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ced_pkg::ced_out_t out_data
);
  import ced_pkg::*;

  logic      stg_valid;
  logic      stg_take;
  ced_in_t   stg_data;
  ced_out_t  rsp;
  logic      out_valid_r;
  logic      out_valid_nxt;
  ced_out_t  out_data_r;
  logic      out_free;

  ced_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .stg_valid (stg_valid),
    .stg_take  (stg_take),
    .stg_data  (stg_data)
  );

  ced_dispatch u_dispatch (
    .req (stg_data),
    .rsp (rsp)
  );

  // The result register takes a new beat when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;
  assign stg_take = stg_valid && out_free;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_take) begin
      out_data_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/ced_in_reg.sv */
// Input register stage of the exception dispatch pipeline.
// Depends on ced_pkg for the input beat type.
module ced_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ced_pkg::ced_in_t in_data,
  output logic            stg_valid,
  input  logic            stg_take,
  output ced_pkg::ced_in_t stg_data
);
  import ced_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  ced_in_t data_r;
  logic    load;

  // The register can take a beat when it is empty or its beat moves on this cycle.
  assign in_stall = valid_r && !stg_take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (stg_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_data;
    end
  end

  assign stg_valid = valid_r;
  assign stg_data  = data_r;

endmodule

/* rtl/ced_dispatch.sv */
// Combinational exception selection and state update for one beat.
// Depends on ced_pkg for beat types, masks and the vector table.
module ced_dispatch (
  input  ced_pkg::ced_in_t  req,
  output ced_pkg::ced_out_t rsp
);
  import ced_pkg::*;

  logic [NUM_EXC-1:0] eligible;
  logic [SEL_W-1:0]   sel;
  logic               hit;
  logic [31:0]        saved_msr;
  logic [31:0]        msr_le;

  // External and decrementer only count while interrupts are enabled.
  always_comb begin
    eligible = req.pending & SYNC_EXC_MASK;
    if ((req.msr_in & MSR_EE) != '0) begin
      eligible = eligible | (req.pending & ASYNC_EXC_MASK);
    end
  end

  // Priority encoder: the lowest set index wins.
  always_comb begin
    sel = '0;
    hit = 1'b0;
    for (int i = NUM_EXC - 1; i >= 0; i--) begin
      if (eligible[i]) begin
        sel = SEL_W'(i);
        hit = 1'b1;
      end
    end
  end

  assign saved_msr = req.msr_in & SRR1_KEEP_MASK;

  // LE takes the value of ILE before the entry bits are cleared.
  always_comb begin
    msr_le              = req.msr_in;
    msr_le[MSR_LE_BIT]  = req.msr_in[MSR_ILE_BIT];
  end

  // Build the result; without a hit every value passes through.
  always_comb begin
    rsp.taken        = 1'b0;
    rsp.cause        = CAUSE_NONE;
    rsp.save_pc_out  = req.save_pc_in;
    rsp.save_msr_out = req.save_msr_in;
    rsp.msr_out      = req.msr_in;
    rsp.next_pc_out  = req.next_pc;
    rsp.pending_out  = req.pending;
    if (hit) begin
      rsp.taken       = 1'b1;
      rsp.cause       = {1'b0, sel} + 4'd1;
      rsp.save_pc_out = USE_NEXT_PC[sel] ? req.next_pc : req.cur_pc;
      case (sel)
        EXC_ISI:     rsp.save_msr_out = req.save_msr_in | saved_msr;
        EXC_PROGRAM: rsp.save_msr_out = saved_msr | PROG_SRR1_BIT;
        default:     rsp.save_msr_out = saved_msr;
      endcase
      rsp.msr_out          = msr_le & ~MSR_CLEAR_MASK;
      rsp.next_pc_out      = VEC_TABLE[sel];
      rsp.pending_out[sel] = 1'b0;
    end
  end

endmodule
